>>> rtl/core/prt_pkg.sv
`default_nettype none
package prt_pkg;

    // Default client count and slot geometry (slots per client is a power of two)
    localparam int CLIENTS_DEF = 32;
    localparam int SLOTS_LOG2  = 3;
    localparam int SLOTS       = 1 << SLOTS_LOG2;

    localparam logic [30:0] TIMEOUT_RST = 31'd5000;
    localparam logic [31:0] RTT_NONE    = 32'hFFFF_FFFF;
    localparam logic [30:0] RTT_MAX     = 31'h7FFF_FFFF;
    localparam logic [8:0]  CNT_MAX     = 9'd511;

    // Request codes
    localparam logic [1:0] REQ_SEND  = 2'd0;
    localparam logic [1:0] REQ_PONG  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_ISSUED   = 3'd0;
    localparam logic [2:0] KIND_MEASURED = 3'd1;
    localparam logic [2:0] KIND_IGNORED  = 3'd2;
    localparam logic [2:0] KIND_REPORTED = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd4;
    localparam logic [2:0] KIND_TICK     = 3'd5;

    // Per-client entry
    typedef struct packed {
        logic        known;
        logic [31:0] next_id;
        logic [30:0] last_rtt;
    } client_ent_t;

    // Per-slot entry
    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [31:0] stamp;
    } slot_ent_t;

endpackage
`default_nettype wire

>>> rtl/core/prt_client_mem.sv
`default_nettype none
module prt_client_mem #(
    parameter int DEPTH = prt_pkg::CLIENTS_DEF,
    parameter int AW    = 5
) (
    input  wire logic                aclk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire prt_pkg::client_ent_t wdata,
    input  wire logic [AW-1:0]       raddr,
    output prt_pkg::client_ent_t     rdata
);

    prt_pkg::client_ent_t mem [DEPTH];
    prt_pkg::client_ent_t rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/core/prt_slot_mem.sv
`default_nettype none
module prt_slot_mem #(
    parameter int DEPTH = prt_pkg::CLIENTS_DEF * prt_pkg::SLOTS,
    parameter int AW    = 8
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire prt_pkg::slot_ent_t wdata,
    input  wire logic [AW-1:0]     raddr,
    output prt_pkg::slot_ent_t     rdata
);

    prt_pkg::slot_ent_t mem [DEPTH];
    prt_pkg::slot_ent_t rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/core/ping_rtt_tracker.sv
// Send, pong and query: the memories are read as the item is accepted and the result is registered in ST_EXEC;
// unknown client: the result is registered as the item is accepted. Tick: the expiry sweep reads one slot per cycle.
// One item at a time; the next item may be accepted as the result is taken.
// Reset (aresetn low, synchronous) is followed by a clearing pass over both memories,
// during which no item is accepted; config writes are taken.
`default_nettype none
module ping_rtt_tracker #(
    parameter int CLIENTS = prt_pkg::CLIENTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [30:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [4:0]  s_client_id,
    input  wire logic [31:0] s_ping_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_result_kind,
    output logic [4:0]       m_out_client,
    output logic [31:0]      m_out_ping_id,
    output logic signed [31:0] m_rtt_ms,
    output logic [8:0]       m_expired_count
);

    localparam int CW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int SL    = prt_pkg::SLOTS_LOG2;
    localparam int AW    = CW + SL;
    localparam int NSLOT = CLIENTS * prt_pkg::SLOTS;
    localparam logic [AW:0]  NSLOT_W   = (AW+1)'(NSLOT);
    localparam logic [AW:0]  CLIENTS_P = (AW+1)'(CLIENTS);
    localparam logic [10:0]  CLIENTS_W = 11'(CLIENTS);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [AW:0] ptr_reg, ptr_next;
    logic [1:0]  req_reg, req_next;
    logic [4:0]  cl_reg, cl_next;
    logic [31:0] pid_reg, pid_next;
    logic        pend_reg, pend_next;
    logic [AW-1:0] paddr_reg, paddr_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [31:0] now_reg, now_next;
    logic [30:0] timeout_reg;

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [4:0]  ocl_reg, ocl_next;
    logic [31:0] opid_reg, opid_next;
    logic [31:0] rtt_reg, rtt_next;
    logic [8:0]  exp_reg, exp_next;

    logic                 c_we;
    logic [CW-1:0]        c_waddr, c_raddr;
    prt_pkg::client_ent_t c_wdata, c_rd;
    logic                 sl_we;
    logic [AW-1:0]        sl_waddr, sl_raddr;
    prt_pkg::slot_ent_t   sl_wdata, sl_rd;

    logic        accept, out_free, in_range;
    logic [31:0] age;
    logic        hit, stale;

    prt_client_mem #(.DEPTH(CLIENTS), .AW(CW)) u_client (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rd)
    );

    prt_slot_mem #(.DEPTH(NSLOT), .AW(AW)) u_slot (
        .aclk(aclk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
        .raddr(sl_raddr), .rdata(sl_rd)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign in_range = {6'd0, s_client_id} < CLIENTS_W;

    // Slot age against the current millisecond counter
    assign age   = now_reg - sl_rd.stamp;
    assign stale = sl_rd.valid && (age > {1'b0, timeout_reg});
    assign hit   = c_rd.known && sl_rd.valid && (sl_rd.tag == pid_reg);

    // Control, memory access and result build
    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        req_next     = req_reg;
        cl_next      = cl_reg;
        pid_next     = pid_reg;
        pend_next    = 1'b0;
        paddr_next   = paddr_reg;
        cnt_next     = cnt_reg;
        now_next     = now_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        ocl_next     = ocl_reg;
        opid_next    = opid_reg;
        rtt_next     = rtt_reg;
        exp_next     = exp_reg;

        c_we     = 1'b0;
        c_waddr  = CW'(cl_reg);
        c_wdata  = c_rd;
        c_raddr  = CW'(s_client_id);
        sl_we    = 1'b0;
        sl_waddr = {CW'(cl_reg), pid_reg[SL-1:0]};
        sl_wdata = sl_rd;
        sl_raddr = {CW'(s_client_id), s_ping_id[SL-1:0]};

        unique case (state_reg)
            ST_CLEAR: begin
                sl_we    = 1'b1;
                sl_waddr = ptr_reg[AW-1:0];
                sl_wdata = '0;
                c_we     = ptr_reg < CLIENTS_P;
                c_waddr  = ptr_reg[CW-1:0];
                c_wdata  = '0;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == NSLOT_W - 1'b1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    req_next = s_req_type;
                    cl_next  = s_client_id;
                    pid_next = s_ping_id;
                    if (s_req_type == prt_pkg::REQ_TICK) begin
                        now_next   = now_reg + 1'b1;
                        ptr_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_SWEEP;
                    end else if (!in_range) begin
                        m_valid_next = 1'b1;
                        kind_next    = prt_pkg::KIND_UNKNOWN;
                        ocl_next     = s_client_id;
                        opid_next    = '0;
                        rtt_next     = prt_pkg::RTT_NONE;
                        exp_next     = '0;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                m_valid_next = 1'b1;
                ocl_next     = cl_reg;
                exp_next     = '0;
                state_next   = ST_IDLE;
                unique case (req_reg)
                    prt_pkg::REQ_SEND: begin
                        c_we             = 1'b1;
                        c_wdata.known    = 1'b1;
                        c_wdata.next_id  = c_rd.next_id + 1'b1;
                        sl_we            = 1'b1;
                        sl_waddr         = {CW'(cl_reg), c_rd.next_id[SL-1:0]};
                        sl_wdata.valid   = 1'b1;
                        sl_wdata.tag     = c_rd.next_id;
                        sl_wdata.stamp   = now_reg;
                        kind_next        = prt_pkg::KIND_ISSUED;
                        opid_next        = c_rd.next_id;
                        rtt_next         = '0;
                    end
                    prt_pkg::REQ_PONG: begin
                        opid_next = pid_reg;
                        if (hit) begin
                            c_we             = 1'b1;
                            c_wdata.last_rtt = age[31] ? prt_pkg::RTT_MAX : age[30:0];
                            sl_we            = 1'b1;
                            sl_wdata.valid   = 1'b0;
                            kind_next        = prt_pkg::KIND_MEASURED;
                            rtt_next = {1'b0, age[31] ? prt_pkg::RTT_MAX : age[30:0]};
                        end else begin
                            kind_next = prt_pkg::KIND_IGNORED;
                            rtt_next  = '0;
                        end
                    end
                    default: begin
                        opid_next = '0;
                        if (c_rd.known) begin
                            kind_next = prt_pkg::KIND_REPORTED;
                            rtt_next  = {1'b0, c_rd.last_rtt};
                        end else begin
                            kind_next = prt_pkg::KIND_UNKNOWN;
                            rtt_next  = prt_pkg::RTT_NONE;
                        end
                    end
                endcase
            end
            ST_SWEEP: begin
                // read one slot per cycle, retire the previous one
                sl_raddr = ptr_reg[AW-1:0];
                if (ptr_reg < NSLOT_W) begin
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg[AW-1:0];
                    ptr_next   = ptr_reg + 1'b1;
                end else begin
                    state_next = ST_DRAIN;
                end
                if (pend_reg && stale) begin
                    sl_we          = 1'b1;
                    sl_waddr       = paddr_reg;
                    sl_wdata.valid = 1'b0;
                    if (cnt_reg != prt_pkg::CNT_MAX) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                m_valid_next = 1'b1;
                kind_next    = prt_pkg::KIND_TICK;
                ocl_next     = '0;
                opid_next    = '0;
                rtt_next     = '0;
                exp_next     = cnt_reg;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            now_reg     <= '0;
            timeout_reg <= prt_pkg::TIMEOUT_RST;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            now_reg     <= now_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        cl_reg    <= cl_next;
        pid_reg   <= pid_next;
        paddr_reg <= paddr_next;
        cnt_reg   <= cnt_next;
        kind_reg  <= kind_next;
        ocl_reg   <= ocl_next;
        opid_reg  <= opid_next;
        rtt_reg   <= rtt_next;
        exp_reg   <= exp_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_out_client    = ocl_reg;
    assign m_out_ping_id   = opid_reg;
    assign m_rtt_ms        = rtt_reg;
    assign m_expired_count = exp_reg;

endmodule
`default_nettype wire

>>> tb/sv/ping_rtt_tracker_tb.sv
`default_nettype none
module ping_rtt_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCLI   = prt_pkg::CLIENTS_DEF;
    localparam int NSLOT  = NCLI * prt_pkg::SLOTS;
    localparam int DRAIN  = NSLOT + 20;

    typedef struct packed {
        logic [1:0]  req;
        logic [4:0]  client;
        logic [31:0] pid;
    } ping_req_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [4:0]         client;
        logic [31:0]        pid;
        logic signed [31:0] rtt;
        logic [8:0]         expired;
    } ping_res_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [30:0]       cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_req_type = '0;
    logic [4:0]        s_client_id = '0;
    logic [31:0]       s_ping_id = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [2:0]        m_result_kind;
    logic [4:0]        m_out_client;
    logic [31:0]       m_out_ping_id;
    logic signed [31:0] m_rtt_ms;
    logic [8:0]        m_expired_count;

    ping_rtt_tracker dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .s_valid, .s_ready, .s_req_type, .s_client_id, .s_ping_id,
        .m_valid, .m_ready, .m_result_kind, .m_out_client, .m_out_ping_id,
        .m_rtt_ms, .m_expired_count
    );

    always #6 aclk = ~aclk;

    // tracker image used for prediction
    logic [30:0] tmo_ms;
    logic [31:0] now_ms;
    logic        cli_known [NCLI];
    logic [31:0] cli_next  [NCLI];
    logic [30:0] cli_rtt   [NCLI];
    logic        slot_busy [NSLOT];
    logic [31:0] slot_tag  [NSLOT];
    logic [31:0] slot_time [NSLOT];

    ping_req_t pend_reqs[$];
    ping_res_t exp_results[$];

    int sender_idle = 0;
    int recv_stall  = 0;
    int hold_left   = 0;
    logic hold_go   = 1'b0;
    int errors      = 0;
    int n_items     = 0;
    int n_results   = 0;
    int kind_seen [8];

    // predicted result of one item, updating the image
    function automatic ping_res_t track_ping(ping_req_t r);
        ping_res_t o;
        int unsigned idx;
        logic [31:0] age;
        int cnt;
        o = '0;
        o.client = r.client;
        if (r.req == prt_pkg::REQ_TICK) begin
            now_ms = now_ms + 1;
            cnt = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (slot_busy[i] && (now_ms - slot_time[i]) > {1'b0, tmo_ms}) begin
                    slot_busy[i] = 1'b0;
                    if (cnt < 511) cnt++;
                end
            end
            o.kind = prt_pkg::KIND_TICK;
            o.client = '0;
            o.expired = cnt[8:0];
        end else if (int'(r.client) >= NCLI) begin
            o.kind = prt_pkg::KIND_UNKNOWN;
            o.rtt = prt_pkg::RTT_NONE;
        end else if (r.req == prt_pkg::REQ_SEND) begin
            idx = r.client * prt_pkg::SLOTS + cli_next[r.client] % prt_pkg::SLOTS;
            o.kind = prt_pkg::KIND_ISSUED;
            o.pid = cli_next[r.client];
            cli_known[r.client] = 1'b1;
            slot_busy[idx] = 1'b1;
            slot_tag[idx] = cli_next[r.client];
            slot_time[idx] = now_ms;
            cli_next[r.client] = cli_next[r.client] + 1;
        end else if (r.req == prt_pkg::REQ_PONG) begin
            idx = r.client * prt_pkg::SLOTS + r.pid % prt_pkg::SLOTS;
            o.pid = r.pid;
            if (cli_known[r.client] && slot_busy[idx] && slot_tag[idx] == r.pid) begin
                age = now_ms - slot_time[idx];
                if (age > {1'b0, prt_pkg::RTT_MAX}) age = {1'b0, prt_pkg::RTT_MAX};
                cli_rtt[r.client] = age[30:0];
                slot_busy[idx] = 1'b0;
                o.kind = prt_pkg::KIND_MEASURED;
                o.rtt = age;
            end else begin
                o.kind = prt_pkg::KIND_IGNORED;
            end
        end else if (cli_known[r.client]) begin
            o.kind = prt_pkg::KIND_REPORTED;
            o.rtt = {1'b0, cli_rtt[r.client]};
        end else begin
            o.kind = prt_pkg::KIND_UNKNOWN;
            o.rtt = prt_pkg::RTT_NONE;
        end
        return o;
    endfunction

    task automatic push_item(logic [1:0] req, logic [4:0] cl, logic [31:0] pid);
        ping_req_t r;
        r = '{req: req, client: cl, pid: pid};
        exp_results.push_back(track_ping(r));
        pend_reqs.push_back(r);
        n_items++;
    endtask

    // random item; pongs are mostly against recent ids
    task automatic push_random(int ncl);
        int sel;
        logic [4:0] cl;
        logic [31:0] pid;
        sel = $urandom_range(0, 99);
        cl = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, ncl - 1));
        pid = $urandom;
        if (sel < 35) begin
            push_item(prt_pkg::REQ_SEND, cl, pid);
        end else if (sel < 70) begin
            if ($urandom_range(0, 9) < 8 && cli_next[cl] != 0)
                pid = cli_next[cl] - 1 - $urandom_range(0, 9);
            push_item(prt_pkg::REQ_PONG, cl, pid);
        end else if (sel < 85) begin
            push_item(prt_pkg::REQ_TICK, cl, pid);
        end else begin
            push_item(prt_pkg::REQ_QUERY, cl, pid);
        end
    endtask

    task automatic wait_idle();
        wait (pend_reqs.size() == 0 && exp_results.size() == 0);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_timeout(logic [30:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tmo_ms = v;
    endtask

    // sender: next item offered once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pend_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle) begin
                ping_req_t r;
                r = pend_reqs.pop_front();
                s_req_type <= r.req;
                s_client_id <= r.client;
                s_ping_id <= r.pid;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
        else if (hold_go) hold_left <= 600;
    end

    // receiver and result check
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ping_res_t e;
            n_results++;
            kind_seen[m_result_kind]++;
            if (exp_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result kind=%0d client=%0d", m_result_kind,
                             m_out_client);
            end else begin
                e = exp_results.pop_front();
                if (e.kind !== m_result_kind || e.client !== m_out_client ||
                    e.pid !== m_out_ping_id || e.rtt !== m_rtt_ms ||
                    e.expired !== m_expired_count) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp k=%0d c=%0d id=%h rtt=%0d x=%0d | ",
                                  "got k=%0d c=%0d id=%h rtt=%0d x=%0d"},
                                 e.kind, e.client, e.pid, e.rtt, e.expired,
                                 m_result_kind, m_out_client, m_out_ping_id,
                                 m_rtt_ms, m_expired_count);
                end
            end
        end
        m_ready <= aresetn && hold_left == 0 && !hold_go &&
                   $urandom_range(0, 99) >= recv_stall;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [30:0] tmo_list [6];
        tmo_list = '{31'd5000, 31'd0, 31'd3, 31'h7FFF_FFFF, 31'd20, 31'd1};
        tmo_ms = prt_pkg::TIMEOUT_RST;
        now_ms = '0;
        for (int i = 0; i < NCLI; i++) begin
            cli_known[i] = 1'b0; cli_next[i] = '0; cli_rtt[i] = '0;
        end
        for (int i = 0; i < NSLOT; i++) begin
            slot_busy[i] = 1'b0; slot_tag[i] = '0; slot_time[i] = '0;
        end
        for (int i = 0; i < 8; i++) kind_seen[i] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: match, duplicate, unknown, overwrite, query before pong
        push_item(prt_pkg::REQ_QUERY, 5'd31, 32'hFFFF_FFFF);
        push_item(prt_pkg::REQ_PONG, 5'd31, 32'd0);
        push_item(prt_pkg::REQ_SEND, 5'd0, 32'd0);
        push_item(prt_pkg::REQ_QUERY, 5'd0, 32'd0);
        push_item(prt_pkg::REQ_TICK, 5'd0, 32'd0);
        push_item(prt_pkg::REQ_PONG, 5'd0, 32'd0);
        push_item(prt_pkg::REQ_PONG, 5'd0, 32'd0);
        push_item(prt_pkg::REQ_QUERY, 5'd0, 32'd0);
        for (int i = 0; i < 9; i++) push_item(prt_pkg::REQ_SEND, 5'd31, 32'd0);
        push_item(prt_pkg::REQ_PONG, 5'd31, 32'd0);
        push_item(prt_pkg::REQ_TICK, 5'd31, 32'hFFFF_FFFF);
        push_item(prt_pkg::REQ_PONG, 5'd31, 32'd8);
        push_item(prt_pkg::REQ_PONG, 5'd31, 32'hFFFF_FFFF);
        push_item(prt_pkg::REQ_QUERY, 5'd31, 32'd0);
        wait_idle();

        // random phases over timeouts and idle patterns
        for (int p = 0; p < 6; p++) begin
            if (p != 0) write_timeout(tmo_list[p]);
            case (p % 4)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 48; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 48; end
                default: begin sender_idle = 10; recv_stall = 10; end
            endcase
            for (int i = 0; i < 80; i++) push_random(p < 3 ? 4 : 8);
            if (p == 2) begin
                @(posedge aclk);
                hold_go <= 1'b1;
                @(posedge aclk);
                hold_go <= 1'b0;
            end
            wait_idle();
        end

        $display("%0d items, %0d results; issued %0d, measured %0d, ignored %0d,",
                 n_items, n_results, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("reported %0d, unknown %0d, ticks %0d; six timeout settings",
                 kind_seen[3], kind_seen[4], kind_seen[5]);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
rtl/core/prt_pkg.sv
rtl/core/prt_client_mem.sv
rtl/core/prt_slot_mem.sv
rtl/core/ping_rtt_tracker.sv
tb/sv/ping_rtt_tracker_tb.sv
